/* rtl/core/otf_pkg.sv */
// Package for the one-pole TPT filter: widths, register indexes, mode codes,
// the controller-to-datapath command struct and fixed-point helper functions.
// No dependencies.
package otf_pkg;

    // Field and coefficient widths
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 20;
    localparam int INTEG_BITS     = SAMPLE_BITS + 8;
    localparam int MODE_BITS      = 2;
    localparam int GAIN_BITS      = 24;
    localparam int NORM_BITS      = 21;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = GAIN_BITS;

    // Working widths, sized from the value bounds of each term
    localparam int COEF_OP_W = GAIN_BITS + 1;                               // signed coef operand
    localparam int GX_W      = GAIN_BITS + SAMPLE_BITS - COEF_FRAC_BITS + 2;
    localparam int T_W       = ((GX_W > INTEG_BITS) ? GX_W : INTEG_BITS) + 1;
    localparam int LP_W      = T_W + NORM_BITS - COEF_FRAC_BITS + 2;
    localparam int D_W       = ((LP_W > SAMPLE_BITS) ? LP_W : SAMPLE_BITS) + 1;
    localparam int P_W       = COEF_OP_W + D_W;                             // product width
    localparam int RND_W     = P_W + 1 - COEF_FRAC_BITS;                    // rounded product
    localparam int SUM_W     = RND_W + 1;                                   // gd + lp

    // Rounding constant and register reset values
    localparam logic [P_W:0]           ROUND_HALF = (P_W+1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [NORM_BITS-1:0]   NORM_RESET = NORM_BITS'(1) << COEF_FRAC_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NORM = 2'd2;

    // Filter modes; other codes give zero output
    localparam logic [MODE_BITS-1:0] MODE_LP = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_HP = 2'd1;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MUL_GX = 2'd0,   // g * x
        MUL_LP = 2'd1,   // t * g1
        MUL_GD = 2'd2    // g * (x - lp)
    } t_mul_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;     // capture input beat, apply clear
        logic     mul_en;   // register a product
        t_mul_sel mul_sel;
        logic     t_en;     // t = rnd(g*x) + s
        logic     lp_en;    // lp = rnd(t*g1)
        logic     upd;      // integrator update and output write
    } t_dp_cmd;

    // Shift right by COEF_FRAC_BITS, rounding half up
    function automatic logic signed [RND_W-1:0] round_shift(input logic signed [P_W-1:0] p);
        logic signed [P_W:0] ext;
        logic signed [P_W:0] sh;
        ext = {p[P_W-1], p} + ROUND_HALF;
        sh  = ext >>> COEF_FRAC_BITS;
        return sh[RND_W-1:0];
    endfunction

    // Saturate to the integrator width
    function automatic logic signed [INTEG_BITS-1:0] sat_integ(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-INTEG_BITS:0] hi;
        hi = v[SUM_W-1:INTEG_BITS-1];
        if ((&hi) || !(|hi)) begin
            return v[INTEG_BITS-1:0];
        end
        return v[SUM_W-1] ? {1'b1, {(INTEG_BITS-1){1'b0}}} : {1'b0, {(INTEG_BITS-1){1'b1}}};
    endfunction

    // Saturate to the sample width
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [D_W-1:0] v
    );
        logic [D_W-SAMPLE_BITS:0] hi;
        hi = v[D_W-1:SAMPLE_BITS-1];
        if ((&hi) || !(|hi)) begin
            return v[SAMPLE_BITS-1:0];
        end
        return v[D_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

endpackage

/* rtl/core/otf_ctrl.sv */
// Sequencer for the one-pole TPT filter: steps the shared multiplier through
// g*x, t*g1 and g*d, and owns the input ready and output valid flags.
// Depends on otf_pkg.
module otf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output otf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_GX   = 7'b0000010,
        ST_T    = 7'b0000100,
        ST_LP   = 7'b0001000,
        ST_LPR  = 7'b0010000,
        ST_GD   = 7'b0100000,
        ST_UPD  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Output slot can take a result when empty or being drained
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = otf_pkg::MUL_GX;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_GX;
                end
            end
            ST_GX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = otf_pkg::MUL_GX;
                n_state       = ST_T;
            end
            ST_T: begin
                o_cmd.t_en = 1'b1;
                n_state    = ST_LP;
            end
            ST_LP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = otf_pkg::MUL_LP;
                n_state       = ST_LPR;
            end
            ST_LPR: begin
                o_cmd.lp_en = 1'b1;
                n_state     = ST_GD;
            end
            ST_GD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = otf_pkg::MUL_GD;
                n_state       = ST_UPD;
            end
            ST_UPD: begin
                // hold here until the output slot frees up
                if (out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        if (o_cmd.upd) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/otf_dp.sv */
// Datapath for the one-pole TPT filter: configuration registers, integrator,
// one shared signed multiplier with rounding, saturation and output register.
// Depends on otf_pkg.
module otf_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  otf_pkg::t_dp_cmd                      i_cmd,
    input  logic                                  i_cfg_we,
    input  logic [otf_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [otf_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic signed [otf_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                  i_clear,
    input  logic                                  i_last,
    output logic signed [otf_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                  o_last
);

    localparam int SB  = otf_pkg::SAMPLE_BITS;
    localparam int IB  = otf_pkg::INTEG_BITS;
    localparam int CW  = otf_pkg::COEF_OP_W;
    localparam int DW  = otf_pkg::D_W;
    localparam int TW  = otf_pkg::T_W;
    localparam int GW  = otf_pkg::GX_W;
    localparam int LW  = otf_pkg::LP_W;
    localparam int PW  = otf_pkg::P_W;
    localparam int RW  = otf_pkg::RND_W;
    localparam int SW  = otf_pkg::SUM_W;

    // Configuration
    logic [otf_pkg::MODE_BITS-1:0] r_mode;
    logic [otf_pkg::GAIN_BITS-1:0] r_gain;
    logic [otf_pkg::NORM_BITS-1:0] r_norm;

    // State and working registers
    logic signed [IB-1:0] r_integ;
    logic signed [SB-1:0] r_x;
    logic                 r_last;
    logic signed [PW-1:0] r_prod;
    logic signed [TW-1:0] r_t;
    logic signed [LW-1:0] r_lp;
    logic signed [DW-1:0] r_d;
    logic signed [SB-1:0] r_out;
    logic                 r_out_last;

    logic signed [CW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [RW-1:0] rnd;
    logic signed [DW-1:0] x_ext;
    logic signed [DW-1:0] lp_ext;
    logic signed [DW-1:0] d;
    logic signed [SW-1:0] integ_sum;
    logic                 active;

    assign x_ext  = {{(DW-SB){r_x[SB-1]}}, r_x};
    assign lp_ext = {{(DW-LW){r_lp[LW-1]}}, r_lp};
    assign d      = x_ext - lp_ext;
    assign rnd    = otf_pkg::round_shift(r_prod);
    assign active = (r_mode == otf_pkg::MODE_LP) || (r_mode == otf_pkg::MODE_HP);

    // Multiplier operand selection
    always_comb begin
        case (i_cmd.mul_sel)
            otf_pkg::MUL_GX: begin
                mul_a = {1'b0, r_gain};
                mul_b = x_ext;
            end
            otf_pkg::MUL_LP: begin
                mul_a = {{(CW-otf_pkg::NORM_BITS){1'b0}}, r_norm};
                mul_b = {{(DW-TW){r_t[TW-1]}}, r_t};
            end
            otf_pkg::MUL_GD: begin
                mul_a = {1'b0, r_gain};
                mul_b = d;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // New integrator value: rnd(g*d) + lp
    assign integ_sum = {rnd[RW-1], rnd} + {{(SW-LW){r_lp[LW-1]}}, r_lp};

    // Config registers and integrator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= otf_pkg::MODE_LP;
            r_gain  <= '0;
            r_norm  <= otf_pkg::NORM_RESET;
            r_integ <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    otf_pkg::REG_MODE: r_mode <= i_cfg_data[otf_pkg::MODE_BITS-1:0];
                    otf_pkg::REG_GAIN: r_gain <= i_cfg_data[otf_pkg::GAIN_BITS-1:0];
                    otf_pkg::REG_NORM: r_norm <= i_cfg_data[otf_pkg::NORM_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load && i_clear) begin
                r_integ <= '0;
            end else if (i_cmd.upd && active) begin
                r_integ <= otf_pkg::sat_integ(integ_sum);
            end
        end
    end

    // Working pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample;
            r_last <= i_last;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
        end
        if (i_cmd.t_en) begin
            r_t <= {{(TW-GW){rnd[GW-1]}}, rnd[GW-1:0]} + {{(TW-IB){r_integ[IB-1]}}, r_integ};
        end
        if (i_cmd.lp_en) begin
            r_lp <= rnd[LW-1:0];
        end
        if (i_cmd.mul_en && (i_cmd.mul_sel == otf_pkg::MUL_GD)) begin
            r_d <= d;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out_last <= r_last;
            case (r_mode)
                otf_pkg::MODE_LP: r_out <= otf_pkg::sat_sample(lp_ext);
                otf_pkg::MODE_HP: r_out <= otf_pkg::sat_sample(r_d);
                default:          r_out <= '0;
            endcase
        end
    end

    assign o_sample = r_out;
    assign o_last   = r_out_last;

endmodule

/* rtl/core/one_pole_tpt_filter.sv */
// Top level of the one-pole TPT filter: stream ports, configuration port,
// sequencer and datapath. Depends on otf_pkg, otf_ctrl and otf_dp.
//
// One-pole zero-delay-feedback filter on signed Q1.15 samples. Software must write
// the mode (0 low-pass, 1 high-pass, 2 or 3 zero output), the gain g (Q4.20)
// and the normalizer 1/(1+g) (Q1.20) through the write port only while the
// block is idle; the block does not enforce this. A beat accepted in IDLE
// passes GX, T, LP, LPR and GD to UPD, which registers its result; no new
// beat is taken meanwhile, as one multiplier serves g*x, (g*x+s)*g1 and
// g*(x-lp) in turn, with a register after each product and rounding step.
// The result waits in an output register; a stalled output holds the block
// in UPD. A set tuser bit clears the integrator first; tlast passes through.
module one_pole_tpt_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [otf_pkg::SAMPLE_BITS-1:0]        s_axis_tdata,  // [15:0] sample_in
    input  logic                                   s_axis_tuser,  // [0] clear_first
    input  logic                                   s_axis_tlast,  // block_end
    // Output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [otf_pkg::SAMPLE_BITS-1:0]        m_axis_tdata,  // [15:0] sample_out
    output logic                                   m_axis_tlast,  // block_end_out
    // Configuration write port
    input  logic                                   i_cfg_we,
    input  logic [otf_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [otf_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    otf_pkg::t_dp_cmd                     cmd;
    logic signed [otf_pkg::SAMPLE_BITS-1:0] out_sample;

    otf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    otf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   ($signed(s_axis_tdata)),
        .i_clear    (s_axis_tuser),
        .i_last     (s_axis_tlast),
        .o_sample   (out_sample),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = $unsigned(out_sample);

endmodule
